### src/abb_pkg.sv
// Shared types, constants and blend helper for the alpha blend blitter.
package abb_pkg;

    localparam int MaxWidth  = 512;
    localparam int MaxHeight = 512;
    localparam int AddrW     = $clog2(MaxWidth * MaxHeight);
    localparam int DimW      = 10;
    localparam logic [DimW-1:0] MaxWidthC  = DimW'(MaxWidth);
    localparam logic [DimW-1:0] MaxHeightC = DimW'(MaxHeight);

    typedef enum logic [2:0] {
        FUNC_OPEN  = 3'd0,
        FUNC_SRC   = 3'd1,
        FUNC_FILL  = 3'd2,
        FUNC_BLEND = 3'd3,
        FUNC_READ  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BOUNDS  = 2'd1,
        ST_NOWIN   = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [9:0]  rect_width;
        logic [9:0]  rect_height;
        logic [9:0]  skip_count;
        logic [31:0] pixel_argb;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] read_color;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_WRITE,
        S_FILL,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic decode;
        logic mem_read;
        logic mem_write;
        logic fill_start;
        logic fill_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
        logic need_write;
        logic is_fill;
        logic fill_last;
    } dp_stat_t;

    function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                               input logic [7:0] a);
        logic [15:0] ps;
        logic [15:0] pd;
        logic [15:0] sum;
        begin
            ps  = {8'd0, s} * {8'd0, a};
            pd  = {8'd0, d} * {8'd0, 8'd255 - a};
            // The two weights add up to 255, so the sum never exceeds 16 bits.
            sum = ps + pd;
            return sum[15:8];
        end
    endfunction

endpackage

### src/abb_ram.sv
// Generic single-port RAM with registered read.
module abb_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

### src/abb_datapath.sv
// Datapath: window registers, fill walker, address multiply, blend and framebuffer.
module abb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  abb_pkg::dp_cmd_t    cmd,
    output abb_pkg::dp_stat_t   stat,
    input  abb_pkg::in_item_t   item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data,
    output abb_pkg::out_item_t  result
);
    import abb_pkg::*;

    in_item_t      item_reg;
    logic [9:0]    screen_w_reg, screen_h_reg;
    logic [9:0]    win_left_reg, win_right_reg, win_bottom_reg;
    logic [9:0]    cursor_col_reg, cursor_row_reg, gap_length_reg, gap_left_reg;
    logic          window_open_reg;
    logic [1:0]    status_reg;
    logic          need_read_reg, need_write_reg, is_fill_reg;
    logic [AddrW-1:0] addr_reg;
    logic [9:0]    fx_reg, fy_reg, fx_end_reg, fy_end_reg;
    out_item_t     result_reg;

    logic [9:0]    w, h;
    logic [10:0]   xe, ye;
    logic          rect_oob, pix_oob, cur_in;
    logic [9:0]    cur_next;
    logic [9:0]    row_next;
    logic [7:0]    alpha;
    logic [23:0]   rdata, wdata;
    logic [9:0]    ax, ay;
    logic [19:0]   prod;

    assign w = (screen_w_reg > MaxWidthC) ? MaxWidthC : screen_w_reg;
    assign h = (screen_h_reg > MaxHeightC) ? MaxHeightC : screen_h_reg;
    assign xe = {1'b0, item_reg.pos_x} + {1'b0, item_reg.rect_width};
    assign ye = {1'b0, item_reg.pos_y} + {1'b0, item_reg.rect_height};
    assign rect_oob = (xe > {1'b0, w}) || (ye > {1'b0, h});
    assign pix_oob = (item_reg.pos_x >= w) || (item_reg.pos_y >= h);
    assign cur_in = (cursor_col_reg < w) && (cursor_row_reg < h);
    assign cur_next = cursor_col_reg + 10'd1;
    assign row_next = cursor_row_reg + 10'd1;
    assign alpha = item_reg.pixel_argb[31:24];

    // Pixel coordinate used for addressing in this item.
    always_comb
    begin
        ax = item_reg.pos_x;
        ay = item_reg.pos_y;
        if (is_fill_reg)
        begin
            ax = fx_reg;
            ay = fy_reg;
        end
        else if (item_reg.func == FUNC_SRC)
        begin
            ax = cursor_col_reg;
            ay = cursor_row_reg;
        end
    end
    assign prod = ay * w;

    always_comb
    begin
        if (alpha == 8'hFF)
        begin
            wdata = item_reg.pixel_argb[23:0];
        end
        else
        begin
            wdata = {mix_channel(item_reg.pixel_argb[23:16], rdata[23:16], alpha),
                     mix_channel(item_reg.pixel_argb[15:8], rdata[15:8], alpha),
                     mix_channel(item_reg.pixel_argb[7:0], rdata[7:0], alpha)};
        end
    end

    abb_ram #(.Width(24), .Depth(MaxWidth * MaxHeight)) u_ram (
        .clk   (clk),
        .we    (cmd.mem_write),
        .re    (cmd.mem_read),
        .addr  (addr_reg),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg    <= 10'd512;
            screen_h_reg    <= 10'd512;
            win_left_reg    <= '0;
            win_right_reg   <= '0;
            win_bottom_reg  <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            gap_length_reg  <= '0;
            gap_left_reg    <= '0;
            window_open_reg <= 1'b0;
            need_read_reg   <= 1'b0;
            need_write_reg  <= 1'b0;
            is_fill_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    screen_h_reg <= cfg_data;
                end
                else
                begin
                    screen_w_reg <= cfg_data;
                end
            end
            if (cmd.load_item)
            begin
                need_read_reg  <= 1'b0;
                need_write_reg <= 1'b0;
                is_fill_reg    <= 1'b0;
            end
            if (cmd.decode)
            begin
                case (item_reg.func)
                    FUNC_OPEN:
                    begin
                        if (rect_oob)
                        begin
                            window_open_reg <= 1'b0;
                        end
                        else
                        begin
                            win_left_reg    <= item_reg.pos_x;
                            win_right_reg   <= xe[9:0];
                            win_bottom_reg  <= ye[9:0];
                            cursor_col_reg  <= item_reg.pos_x;
                            cursor_row_reg  <= item_reg.pos_y;
                            gap_length_reg  <= item_reg.skip_count;
                            gap_left_reg    <= '0;
                            window_open_reg <= (item_reg.rect_width != '0)
                                               && (item_reg.rect_height != '0);
                        end
                    end
                    FUNC_SRC:
                    begin
                        if (window_open_reg && gap_left_reg != '0)
                        begin
                            gap_left_reg <= gap_left_reg - 10'd1;
                        end
                        else if (window_open_reg)
                        begin
                            need_write_reg <= cur_in && (alpha != 8'd0);
                            need_read_reg  <= cur_in && (alpha != 8'd0) && (alpha != 8'hFF);
                            if (cur_next >= win_right_reg)
                            begin
                                cursor_col_reg <= win_left_reg;
                                cursor_row_reg <= row_next;
                                // The gap after the last row is not awaited.
                                if (row_next >= win_bottom_reg)
                                begin
                                    window_open_reg <= 1'b0;
                                    gap_left_reg    <= '0;
                                end
                                else
                                begin
                                    gap_left_reg <= gap_length_reg;
                                end
                            end
                            else
                            begin
                                cursor_col_reg <= cur_next;
                            end
                        end
                    end
                    FUNC_FILL:
                    begin
                        is_fill_reg <= !rect_oob && (item_reg.rect_width != '0)
                                       && (item_reg.rect_height != '0) && (alpha != 8'd0);
                        need_read_reg <= alpha != 8'hFF;
                    end
                    FUNC_BLEND:
                    begin
                        need_write_reg <= !pix_oob && (alpha != 8'd0);
                        need_read_reg  <= !pix_oob && (alpha != 8'd0) && (alpha != 8'hFF);
                    end
                    FUNC_READ:
                    begin
                        need_read_reg <= !pix_oob;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers: item copy, status, address, fill walker and result.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.decode)
        begin
            fx_reg     <= item_reg.pos_x;
            fy_reg     <= item_reg.pos_y;
            fx_end_reg <= xe[9:0] - 10'd1;
            fy_end_reg <= ye[9:0] - 10'd1;
            addr_reg   <= AddrW'(prod) + AddrW'(ax);
            case (item_reg.func)
                FUNC_OPEN:  status_reg <= rect_oob ? ST_BOUNDS : ST_OK;
                FUNC_SRC:
                begin
                    if (!window_open_reg)
                    begin
                        status_reg <= ST_NOWIN;
                    end
                    else if (gap_left_reg == '0 && !cur_in)
                    begin
                        status_reg <= ST_BOUNDS;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                    end
                end
                FUNC_FILL:  status_reg <= rect_oob ? ST_BOUNDS : ST_OK;
                FUNC_BLEND: status_reg <= pix_oob ? ST_BOUNDS : ST_OK;
                FUNC_READ:  status_reg <= pix_oob ? ST_BOUNDS : ST_OK;
                default:    status_reg <= ST_OK;
            endcase
        end
        if (cmd.fill_start)
        begin
            addr_reg <= AddrW'(prod) + AddrW'(ax);
        end
        if (cmd.fill_step)
        begin
            if (fx_reg == fx_end_reg)
            begin
                fx_reg <= item_reg.pos_x;
                fy_reg <= fy_reg + 10'd1;
            end
            else
            begin
                fx_reg <= fx_reg + 10'd1;
            end
        end
        if (cmd.out_load)
        begin
            // The read data stays in the RAM output register until the next read.
            result_reg.status     <= status_reg;
            result_reg.read_color <= (item_reg.func == FUNC_READ && need_read_reg) ? rdata : '0;
        end
    end

    assign stat.need_read  = need_read_reg;
    assign stat.need_write = need_write_reg;
    assign stat.is_fill    = is_fill_reg;
    assign stat.fill_last  = (fx_reg == fx_end_reg) && (fy_reg == fy_end_reg);
    assign result = result_reg;

`ifndef SYNTHESIS
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_read && cmd.mem_write))
        else $error("framebuffer read and write in one cycle");
    a_win_close_end: assert property (@(posedge clk) disable iff (!rst_n)
        window_open_reg |-> (win_right_reg > win_left_reg))
        else $error("open window with empty width");
    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gap_left_reg <= gap_length_reg)
        else $error("gap counter above gap length");
`endif
endmodule

### src/abb_ctrl.sv
// Controller state machine sequencing decode, read, blend write and fill walks.
module abb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  abb_pkg::dp_stat_t  stat,
    output abb_pkg::dp_cmd_t   cmd
);
    import abb_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (stat.is_fill)
                begin
                    cmd.fill_start = 1'b1;
                    state_next     = S_FILL;
                end
                else
                begin
                    cmd.mem_read = stat.need_read;
                    state_next   = stat.need_write ? S_WRITE : S_DONE;
                end
            end
            S_FILL:
            begin
                // Read phase of a fill pixel; the write follows in S_WRITE.
                cmd.mem_read = stat.need_read;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.mem_write = 1'b1;
                if (stat.is_fill && !stat.fill_last)
                begin
                    cmd.fill_step = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == S_IDLE)
        else $error("item taken outside idle");
    a_write_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_write |-> $past(state_reg) == S_READ || $past(state_reg) == S_FILL)
        else $error("write without preceding read slot");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded but not shown");
`endif
endmodule

### src/alpha_blend_blitter.sv
// Alpha blend blitter top level: handshakes, configuration port and submodules.
// Usage: the host sends one command item on the in channel (in_valid/in_stall)
// and receives exactly one result item on the out channel (out_valid/out_stall).
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// screen width (index 0) and height (index 1); they are taken in any cycle and
// must only be issued while no item is in flight.
// Sequence: an item is taken in idle and decoded in the next cycle; the single
// framebuffer port then reads a touched pixel where the blend or a read needs
// it and writes it in a later state. Open, read, gap pixels and commands that
// write nothing go from decode through S_READ to S_DONE; a pixel blend or a
// drawn source pixel also passes S_WRITE; a fill walks S_READ, S_FILL and
// S_WRITE for each pixel of the rectangle before S_DONE.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item is taken but its result waits until that register is free.
// Reset clears the window state and sets the screen to 512 by 512; the
// framebuffer itself is not cleared, and every pixel must be written before
// it is read or blended.
module alpha_blend_blitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  abb_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output abb_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data
);
    import abb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    abb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    abb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (out_data)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");
    a_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("two items taken back to back");
`endif
endmodule
